>>> rtl/assert_macros.svh
// Assertion macros for the lookup RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

>>> rtl/nlsl_pkg.sv
// Shared constants, operation codes and control structs for the lookup block.
// No dependencies.
`timescale 1ns / 1ps

package nlsl_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES) + 1;

  // Transaction field widths
  localparam int OP_W    = 2;
  localparam int ADDR_W  = 64;
  localparam int MATCH_W = 8;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;  // latch the incoming transaction, reset the scan
    logic issue;   // read the next table entry and advance the scan
    logic finish;  // apply the operation and load the result register
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic lookup;     // latched operation is a lookup
    logic scan_done;  // every valid entry has been read
    logic slot_free;  // result register can take a new result
  } dp_stat_t;

endpackage

>>> rtl/nlsl_ifs.sv
// Valid/ready channel interfaces for the lookup block.
// Depends on nlsl_pkg for field widths.
`timescale 1ns / 1ps

// Request channel: operation and address
interface nlsl_in_if import nlsl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;

  modport source (output valid, operation, address, input ready);
  modport sink   (input valid, operation, address, output ready);
endinterface

// Result channel
interface nlsl_out_if import nlsl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [MATCH_W-1:0] match_index;
  logic [ADDR_W-1:0]  distance;
  logic               table_full;

  modport source (output valid, found, match_index, distance, table_full, input ready);
  modport sink   (input valid, found, match_index, distance, table_full, output ready);
endinterface

>>> rtl/nlsl_ctrl.sv
// Sequencing state machine for the lookup block.
// Depends on nlsl_pkg for the command and status structs.
`timescale 1ns / 1ps

module nlsl_ctrl import nlsl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!stat.lookup)        state_nxt = ST_FINISH;
        else if (stat.scan_done) state_nxt = ST_DRAIN;
      end
      // the drain state lets the last compare reach the best-match registers
      ST_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Commands; no transaction is taken while reset is asserted
  assign in_ready   = rst_n && (state_r == ST_IDLE);
  assign cmd.accept = in_ready && in_valid;
  assign cmd.issue  = (state_r == ST_SCAN) && stat.lookup && !stat.scan_done;
  assign cmd.finish = (state_r == ST_FINISH) && stat.slot_free;

endmodule

>>> rtl/nlsl_dp.sv
// Datapath: start-address table, scan pipeline, best-match tracking, result register.
// Depends on nlsl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nlsl_dp import nlsl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [ADDR_W-1:0]  in_address,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [MATCH_W-1:0] out_match_index,
  output logic [ADDR_W-1:0]  out_distance,
  output logic               out_table_full
);

  // Start-address memory; entries at or above the fill count are never read
  logic [ADDR_W-1:0] mem [MAX_ENTRIES];

  logic [OP_W-1:0]    op_r;
  logic [ADDR_W-1:0]  query_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   scan_r;
  logic [ADDR_W-1:0]  rd_data_r;
  logic               p1_vld_r;
  logic [IDX_W-1:0]   p1_idx_r;
  logic               p2_vld_r;
  logic [IDX_W-1:0]   p2_idx_r;
  logic [ADDR_W-1:0]  p2_dist_r;
  logic               hit_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [ADDR_W-1:0]  best_dist_r;
  logic               out_valid_r;
  logic               out_found_r;
  logic [MATCH_W-1:0] out_match_r;
  logic [ADDR_W-1:0]  out_dist_r;
  logic               out_full_r;

  logic table_is_full;
  logic ins_ok;
  logic take_best;

  assign table_is_full = (cnt_r == CNT_W'(MAX_ENTRIES));
  assign ins_ok        = cmd.finish && (op_r == OP_INSERT) && !table_is_full;

  // Status to the controller
  assign stat.lookup    = (op_r == OP_LOOKUP);
  assign stat.scan_done = (scan_r == cnt_r);
  assign stat.slot_free = !out_valid_r || out_ready;

  // Latched transaction and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_operation;
      query_r <= in_address;
      scan_r  <= '0;
    end else if (cmd.issue) begin
      scan_r  <= scan_r + CNT_W'(1);
    end
  end

  // Memory: write on a successful insert, registered read on scan
  always_ff @(posedge clk) begin
    if (ins_ok) mem[cnt_r[IDX_W-1:0]] <= query_r;
    if (cmd.issue) rd_data_r <= mem[scan_r[IDX_W-1:0]];
  end

  // Fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.finish && (op_r == OP_CLEAR)) cnt_nxt = '0;
    else if (ins_ok)                      cnt_nxt = cnt_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  // Scan pipeline: read, then compare and subtract, then best-match update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= cmd.issue;
      p2_vld_r <= p1_vld_r && (rd_data_r <= query_r);
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r  <= scan_r[IDX_W-1:0];
    p2_idx_r  <= p1_idx_r;
    p2_dist_r <= query_r - rd_data_r;
  end

  // Ascending scan with <= keeps the newest of equal starts
  assign take_best = p2_vld_r && (!hit_r || (p2_dist_r <= best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.accept) begin
      hit_r <= 1'b0;
    end else if (take_best) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      best_dist_r <= '1;
      best_idx_r  <= '0;
    end else if (take_best) begin
      best_dist_r <= p2_dist_r;
      best_idx_r  <= p2_idx_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r <= 1'b0;
      out_match_r <= '0;
      out_dist_r  <= '0;
      out_full_r  <= 1'b0;
      case (op_r)
        OP_INSERT: out_full_r <= table_is_full;
        OP_LOOKUP: begin
          out_found_r <= hit_r;
          out_match_r <= hit_r ? MATCH_W'(best_idx_r) : '0;
          out_dist_r  <= hit_r ? best_dist_r : '1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_match_r;
  assign out_distance    = out_dist_r;
  assign out_table_full  = out_full_r;

  // Checks
  `ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(MAX_ENTRIES))
  `ASSERT_IMP(a_issue_in_range, clk, rst_n, cmd.issue, scan_r < cnt_r)
  `ASSERT_NXT(a_miss_result, clk, rst_n, cmd.finish && (op_r == OP_LOOKUP) && !hit_r,
              out_valid_r && !out_found_r && (out_dist_r == '1) && (out_match_r == '0))
  `ASSERT_NXT(a_pipe_drained, clk, rst_n, cmd.finish, !p1_vld_r && !p2_vld_r)

endmodule

>>> rtl/nearest_lower_start_lookup.sv
// Top level of the nearest-lower-start lookup: controller plus datapath.
// Depends on nlsl_pkg, nlsl_ifs, nlsl_ctrl and nlsl_dp.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      operation[1:0], address[63:0]
//   out_ch   out  valid / ready      found, match_index[7:0], distance[63:0], table_full
//
// Insert, clear and unknown operations go from accept through the scan state to finish.
// A lookup scans the N valid entries (N is the fill count), drains, then finishes;
// the scan reads one table entry per cycle through the single memory read port.
// Reset (synchronous, active low) empties the table; table contents are not cleared.
// One transaction is in work at a time; a waiting result does not block the next
// accept, but the following result waits until the output register is taken.
`timescale 1ns / 1ps

module nearest_lower_start_lookup import nlsl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  nlsl_in_if.sink     in_ch,
  nlsl_out_if.source  out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  nlsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table and result datapath
  nlsl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_ch.operation),
    .in_address      (in_ch.address),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_found       (out_ch.found),
    .out_match_index (out_ch.match_index),
    .out_distance    (out_ch.distance),
    .out_table_full  (out_ch.table_full)
  );

endmodule

>>> tb/tb.sv
// Self-checking testbench for nearest_lower_start_lookup: directed table, then random episodes.
// Depends on nlsl_pkg, nlsl_ifs and the block's RTL; carries its own table predictor.
`timescale 1ns / 1ps

module tb;
  import nlsl_pkg::*;

  typedef logic [OP_W-1:0]   op_code_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_index;
    addr_t              distance;
    logic               table_full;
  } lookup_result_t;

  // One directed row: reps > 1 repeats the row with address + k
  typedef struct packed {
    op_code_t       op;
    addr_t          addr;
    logic [9:0]     reps;
    logic           typed;
    lookup_result_t want;
  } stim_row_t;

  localparam op_code_t       OP_UNUSED   = 2'd3;  // no meaning; block returns an empty result
  localparam addr_t          ALL_ONES    = '1;
  localparam addr_t          SIGN_BIT    = 64'h8000_0000_0000_0000;
  localparam lookup_result_t RES_NONE    = '0;
  localparam lookup_result_t RES_MISS    = '{1'b0, 8'd0, ALL_ONES, 1'b0};
  localparam lookup_result_t RES_FULL    = '{1'b0, 8'd0, 64'd0, 1'b1};
  localparam int             ITEMS       = 1120;  // random part; the table adds about 280
  localparam int             N_DIRECTED  = 25;
  localparam int unsigned    CYCLE_LIMIT = 2_000_000;

  logic clk;
  logic rst_n;

  nlsl_in_if  in_ch ();
  nlsl_out_if out_ch ();

  nearest_lower_start_lookup u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: region starts in insertion order
  addr_t          region_starts [MAX_ENTRIES];
  int unsigned    region_count;
  lookup_result_t pending_results [$];

  int          fail_count;
  int          random_items;
  int          src_idle_pct;
  int          snk_idle_pct;
  bit          hold_request;
  int unsigned cycle_count;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_LOOKUP, 64'd0,        10'd1, 1'b1, RES_MISS},                         // empty table
    '{OP_LOOKUP, ALL_ONES,     10'd1, 1'b1, RES_MISS},
    '{OP_INSERT, 64'd0,        10'd1, 1'b1, RES_NONE},
    '{OP_INSERT, ALL_ONES,     10'd1, 1'b1, RES_NONE},
    '{OP_LOOKUP, 64'd0,        10'd1, 1'b1, '{1'b1, 8'd0, 64'd0, 1'b0}},
    '{OP_LOOKUP, ALL_ONES,     10'd1, 1'b1, '{1'b1, 8'd1, 64'd0, 1'b0}},
    '{OP_LOOKUP, SIGN_BIT,     10'd1, 1'b1, '{1'b1, 8'd0, SIGN_BIT, 1'b0}},   // unsigned compare
    '{OP_INSERT, 64'd0,        10'd1, 1'b1, RES_NONE},                         // duplicate start
    '{OP_LOOKUP, 64'd5,        10'd1, 1'b1, '{1'b1, 8'd2, 64'd5, 1'b0}},      // newest wins
    '{OP_UNUSED, ALL_ONES,     10'd1, 1'b1, RES_NONE},
    '{OP_LOOKUP, 64'd5,        10'd1, 1'b1, '{1'b1, 8'd2, 64'd5, 1'b0}},      // state kept
    '{OP_CLEAR,  ALL_ONES,     10'd1, 1'b1, RES_NONE},
    '{OP_LOOKUP, ALL_ONES,     10'd1, 1'b1, RES_MISS},
    '{OP_INSERT, 64'h1000,     10'd1, 1'b1, RES_NONE},
    '{OP_LOOKUP, 64'h0fff,     10'd1, 1'b1, RES_MISS},                         // all starts above
    '{OP_LOOKUP, 64'h1000,     10'd1, 1'b1, '{1'b1, 8'd0, 64'd0, 1'b0}},
    '{OP_CLEAR,  64'd0,        10'd1, 1'b1, RES_NONE},
    '{OP_INSERT, 64'h1_0000,   10'(MAX_ENTRIES), 1'b1, RES_NONE},              // fill up
    '{OP_INSERT, 64'd0,        10'd1, 1'b1, RES_FULL},                         // refused
    '{OP_LOOKUP, ALL_ONES,     10'd1, 1'b0, RES_NONE},
    '{OP_LOOKUP, 64'h1_0080,   10'd1, 1'b0, RES_NONE},
    '{OP_LOOKUP, 64'hffff,     10'd1, 1'b1, RES_MISS},
    '{OP_CLEAR,  64'd0,        10'd1, 1'b1, RES_NONE},
    '{OP_INSERT, 64'd7,        10'd1, 1'b1, RES_NONE},
    '{OP_LOOKUP, 64'd7,        10'd1, 1'b1, '{1'b1, 8'd0, 64'd0, 1'b0}}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Table behavior for one accepted transaction; updates the predictor state
  function automatic lookup_result_t predict_request(input op_code_t op, input addr_t addr);
    lookup_result_t res;
    addr_t          gap;
    res = RES_NONE;
    case (op)
      OP_INSERT: begin
        if (region_count >= MAX_ENTRIES) begin
          res.table_full = 1'b1;
        end else begin
          region_starts[region_count] = addr;
          region_count++;
        end
      end
      OP_LOOKUP: begin
        res.distance = ALL_ONES;
        for (int i = 0; i < region_count; i++) begin
          if (region_starts[i] <= addr) begin
            gap = addr - region_starts[i];
            // ascending scan, <= lets the newest equal start win
            if (!res.found || gap <= res.distance) begin
              res.found       = 1'b1;
              res.distance    = gap;
              res.match_index = MATCH_W'(i);
            end
          end
        end
      end
      OP_CLEAR: region_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic addr_t extreme_addr();
    case ($urandom_range(3))
      0: return '0;
      1: return ALL_ONES;
      2: return SIGN_BIT;
      default: return SIGN_BIT - 64'd1;
    endcase
  endfunction

  // Start address near the episode base, a duplicate, or anywhere
  function automatic addr_t choose_start(input addr_t base);
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return base + $urandom_range(200);
    if (pick < 55 && region_count > 0) return region_starts[$urandom_range(region_count - 1)];
    if (pick < 80) return {$urandom, $urandom};
    if (pick < 92) return base - $urandom_range(200);
    return extreme_addr();
  endfunction

  // Offer one transaction, wait for acceptance, queue its expected result
  task automatic send_request(input op_code_t op, input addr_t addr, input logic use_typed,
                              input lookup_result_t typed_want);
    lookup_result_t predicted;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.address   <= addr;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    predicted = predict_request(op, addr);
    pending_results.push_back(use_typed ? typed_want : predicted);
  endtask

  // Random transaction plus idle pacing by progress
  task automatic send_counted(input op_code_t op, input addr_t addr);
    send_request(op, addr, 1'b0, RES_NONE);
    if (op != OP_UNUSED) begin
      random_items++;
      if (random_items == ITEMS / 3) begin
        src_idle_pct = 85;
        snk_idle_pct = 33;
      end else if (random_items == 2 * ITEMS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_request = 1'b1;
      end
    end
  endtask

  // Result side: check accepted results, drive ready
  initial begin : result_sink
    lookup_result_t want;
    lookup_result_t got;
    int             hold_left;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.found, out_ch.match_index, out_ch.distance, out_ch.table_full};
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: found=%0b idx=%0d dist=%h full=%0b",
                     got.found, got.match_index, got.distance, got.table_full);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found || got.match_index !== want.match_index ||
              got.distance !== want.distance || got.table_full !== want.table_full) begin
            if (fail_count < 10)
              $display({"mismatch: exp found=%0b idx=%0d dist=%h full=%0b, ",
                        "got found=%0b idx=%0d dist=%h full=%0b"},
                       want.found, want.match_index, want.distance, want.table_full,
                       got.found, got.match_index, got.distance, got.table_full);
            fail_count++;
          end
        end
      end
      // long hold-off so the block backs up into the input channel
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 400;
      end
      if (!rst_n || hold_left > 0) begin
        if (hold_left > 0) hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    addr_t       base;
    addr_t       query;
    int unsigned fill;
    int unsigned n_queries;
    int          pick;
    fail_count      = 0;
    random_items    = 0;
    region_count    = 0;
    hold_request    = 1'b0;
    src_idle_pct    = 33;
    snk_idle_pct    = 85;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_CLEAR;
    in_ch.address   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++)
        send_request(directed_rows[r].op, directed_rows[r].addr + k,
                     directed_rows[r].typed, directed_rows[r].want);
    end

    // Random episodes: clear, fill, then mostly lookups with some noise
    while (random_items < ITEMS) begin
      fill      = ($urandom_range(99) < 6) ? $urandom_range(MAX_ENTRIES - 16, MAX_ENTRIES + 4)
                                           : $urandom_range(1, 24);
      n_queries = (fill > 64) ? $urandom_range(6, 14) : $urandom_range(4, 30);
      base      = {$urandom, $urandom};
      send_counted(OP_CLEAR, {$urandom, $urandom});
      repeat (fill) send_counted(OP_INSERT, choose_start(base));
      repeat (n_queries) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          pick = $urandom_range(99);
          if (pick < 50 && region_count > 0)
            query = region_starts[$urandom_range(region_count - 1)] + $urandom_range(40);
          else if (pick < 62 && region_count > 0)
            query = region_starts[$urandom_range(region_count - 1)] - 64'd1;
          else if (pick < 75)
            query = base + $urandom_range(300);
          else if (pick < 88)
            query = {$urandom, $urandom};
          else
            query = extreme_addr();
          send_counted(OP_LOOKUP, query);
        end else if (pick < 95) begin
          send_counted(OP_INSERT, choose_start(base));
        end else if (pick < 98) begin
          send_counted(OP_UNUSED, {$urandom, $urandom});
        end else begin
          send_counted(OP_CLEAR, {$urandom, $urandom});
        end
      end
    end

    // Drain, then allow one full scan for anything stray
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (MAX_ENTRIES + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
